// ===== hw/rtl/crc32_length_prefixed_framer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Framer assertion macros
// Shared property templates for the framer's port checker.
// ----------------------------------------------------------------------------
`ifndef CRC32_LENGTH_PREFIXED_FRAMER_UNIT_ASSERT_SVH
`define CRC32_LENGTH_PREFIXED_FRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, muted while reset is high
`define CLPF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted while reset is high
`define CLPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/clpf_pkg.sv =====
// ----------------------------------------------------------------------------
// Framer package
// Types, constants and the CRC-32 byte update shared by the framer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package clpf_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned LEN_W     = 16;
   localparam int unsigned CRC_W     = 32;
   localparam int unsigned HDR_BYTES = 2;
   localparam int unsigned CRC_BYTES = 4;
   localparam int unsigned RUN_SLOTS = HDR_BYTES + 1 + CRC_BYTES;
   localparam int unsigned CNT_W     = $clog2(RUN_SLOTS + 1);

   localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_CRC     = 2'd2
   } byte_kind_type;

   // Request held in the intake register
   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic [LEN_W-1:0]  frame_length;  // zero already mapped to one
      logic [CRC_W-1:0]  header_crc;    // CRC over the two header bytes from zero
   } item_type;

   // One request's worth of output bytes, slot 0 goes out first
   typedef struct packed {
      logic [RUN_SLOTS-1:0][BYTE_W-1:0] data;
      byte_kind_type [RUN_SLOTS-1:0]    kind;
      logic [CNT_W-1:0]                 count;
      logic                             frame_done;
   } run_type;

   // MSB-first CRC-32 update by one byte, no reflection
   function automatic logic [CRC_W-1:0] crc_feed_byte(input logic [CRC_W-1:0] crc_in,
                                                      input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] crc;
      crc = crc_in ^ {data, {(CRC_W - BYTE_W){1'b0}}};
      for (int i = 0; i < BYTE_W; i++) begin
         if (crc[CRC_W-1]) begin
            crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc = {crc[CRC_W-2:0], 1'b0};
         end
      end
      return crc;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/clpf_if.sv =====
// ----------------------------------------------------------------------------
// Framer channel interfaces
// Valid/ready channels for payload requests and framed output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface clpf_req_if;
   import clpf_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] payload_byte;
   logic [LEN_W-1:0]  frame_length;

   modport source (output valid, output payload_byte, output frame_length, input ready);
   modport sink   (input valid, input payload_byte, input frame_length, output ready);
endinterface

interface clpf_rsp_if;
   import clpf_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic [1:0]        byte_kind;
   logic              end_of_frame;
   logic              last_of_run;

   modport source (output valid, output out_byte, output byte_kind,
                   output end_of_frame, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input byte_kind,
                   input end_of_frame, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/clpf_intake.sv =====
// ----------------------------------------------------------------------------
// Framer intake stage
// Registers each request with its clamped length and precomputed header CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module clpf_intake (
   input  wire logic               clock,
   input  wire logic               reset,
   clpf_req_if.sink                req_chan,
   output clpf_pkg::item_type      item,
   output logic                    item_valid,
   input  wire logic               item_take
);
   import clpf_pkg::*;

   logic             valid_ff, valid_in;
   item_type         item_ff, item_in;
   logic [LEN_W-1:0] len_fixed;
   logic [CRC_W-1:0] crc_hi;
   logic             accept;

   // Open the stage when empty or when the held request moves on this cycle
   assign req_chan.ready = !valid_ff || item_take;
   assign accept         = req_chan.valid && req_chan.ready;

   // Clamp length and fold the header bytes into the CRC
   always_comb begin
      len_fixed = (req_chan.frame_length == '0) ? LEN_W'(1) : req_chan.frame_length;
      crc_hi    = crc_feed_byte('0, len_fixed[LEN_W-1:BYTE_W]);
      item_in.payload_byte = req_chan.payload_byte;
      item_in.frame_length = len_fixed;
      item_in.header_crc   = crc_feed_byte(crc_hi, len_fixed[BYTE_W-1:0]);
   end

   // Track occupancy
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/clpf_build.sv =====
// ----------------------------------------------------------------------------
// Framer run builder
// Advances the frame state and lays out the output bytes of one request.
// ----------------------------------------------------------------------------
`default_nettype none

module clpf_build (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire clpf_pkg::item_type item,
   input  wire logic               item_valid,
   output logic                    item_take,
   input  wire logic               run_free,
   output clpf_pkg::run_type       run
);
   import clpf_pkg::*;

   logic [CRC_W-1:0] crc_ff, crc_in;
   logic [LEN_W-1:0] remaining_ff, remaining_in;
   logic             in_frame_ff, in_frame_in;

   logic             first;
   logic [CRC_W-1:0] crc_base;
   logic [CRC_W-1:0] crc_next;
   logic [LEN_W-1:0] remaining_base;
   logic [LEN_W-1:0] remaining_next;
   logic             done;

   assign item_take = item_valid && run_free;

   // Update CRC and byte count for this request
   always_comb begin
      first          = !in_frame_ff;
      crc_base       = first ? item.header_crc : crc_ff;
      remaining_base = first ? item.frame_length : remaining_ff;
      crc_next       = crc_feed_byte(crc_base, item.payload_byte);
      remaining_next = remaining_base - LEN_W'(1);
      done           = (remaining_next == '0);
   end

   // Lay out header, payload and CRC bytes in emit order
   always_comb begin
      run.data = '0;
      for (int i = 0; i < RUN_SLOTS; i++) begin
         run.kind[i] = KIND_PAYLOAD;
      end
      if (first) begin
         run.data[0] = item.frame_length[LEN_W-1:BYTE_W];
         run.kind[0] = KIND_HEADER;
         run.data[1] = item.frame_length[BYTE_W-1:0];
         run.kind[1] = KIND_HEADER;
         run.data[HDR_BYTES] = item.payload_byte;
         for (int i = 0; i < CRC_BYTES; i++) begin
            run.data[HDR_BYTES+1+i] = crc_next[CRC_W-1-BYTE_W*i -: BYTE_W];
            run.kind[HDR_BYTES+1+i] = KIND_CRC;
         end
      end else begin
         run.data[0] = item.payload_byte;
         for (int i = 0; i < CRC_BYTES; i++) begin
            run.data[1+i] = crc_next[CRC_W-1-BYTE_W*i -: BYTE_W];
            run.kind[1+i] = KIND_CRC;
         end
      end
      run.count = (first ? CNT_W'(HDR_BYTES + 1) : CNT_W'(1))
                + (done ? CNT_W'(CRC_BYTES) : CNT_W'(0));
      run.frame_done = done;
   end

   // Advance frame state, drop back to idle at frame end
   always_comb begin
      crc_in       = crc_ff;
      remaining_in = remaining_ff;
      in_frame_in  = in_frame_ff;
      if (item_take) begin
         if (done) begin
            crc_in      = '0;
            in_frame_in = 1'b0;
         end else begin
            crc_in      = crc_next;
            in_frame_in = 1'b1;
         end
         remaining_in = remaining_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= '0;
         remaining_ff <= '0;
         in_frame_ff  <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         remaining_ff <= remaining_in;
         in_frame_ff  <= in_frame_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/clpf_emit.sv =====
// ----------------------------------------------------------------------------
// Framer output stage
// Shift register that hands out one request's bytes, one per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module clpf_emit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire clpf_pkg::run_type run,
   input  wire logic              run_load,
   output logic                   run_free,
   clpf_rsp_if.source             rsp_chan
);
   import clpf_pkg::*;

   logic [RUN_SLOTS-1:0][BYTE_W-1:0] data_ff, data_in;
   byte_kind_type [RUN_SLOTS-1:0]    kind_ff, kind_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic                             done_ff, done_in;
   logic                             take;
   logic                             last;

   assign last     = (count_ff == CNT_W'(1));
   assign take     = rsp_chan.valid && rsp_chan.ready;
   assign run_free = (count_ff == '0) || (last && rsp_chan.ready);

   // Load a new run, or shift one byte out on each handshake
   always_comb begin
      data_in  = data_ff;
      kind_in  = kind_ff;
      count_in = count_ff;
      done_in  = done_ff;
      if (run_load) begin
         data_in  = run.data;
         kind_in  = run.kind;
         count_in = run.count;
         done_in  = run.frame_done;
      end else if (take) begin
         for (int i = 0; i < RUN_SLOTS - 1; i++) begin
            data_in[i] = data_ff[i+1];
            kind_in[i] = kind_ff[i+1];
         end
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      kind_ff <= kind_in;
      done_ff <= done_in;
   end

   // Drive the response from slot zero
   assign rsp_chan.valid        = (count_ff != '0);
   assign rsp_chan.out_byte     = data_ff[0];
   assign rsp_chan.byte_kind    = kind_ff[0];
   assign rsp_chan.last_of_run  = last;
   assign rsp_chan.end_of_frame = last && done_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/crc32_length_prefixed_framer_unit.sv =====
// ----------------------------------------------------------------------------
// Length-prefixed CRC-32 framer
// Wraps payload bytes with a big-endian length header and trailing CRC-32.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   req_chan  in         payload_byte, frame_length (read on first byte only)
//   rsp_chan  out        out_byte, byte_kind, end_of_frame, last_of_run
//
// A request enters the intake register, then is expanded combinationally into a
// run of 1 to 7 bytes that is loaded into the output shift register.
// Payload-only requests flow at one per cycle while the output is ready; a
// frame's first request adds the two header bytes and its last request the
// four CRC bytes, as the output port moves one byte per handshake.
// A stalled output holds its byte; up to one request waits in the intake stage.
// Reset is synchronous and returns the block to awaiting a frame's first byte.
//
`default_nettype none

module crc32_length_prefixed_framer_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   clpf_req_if.sink   req_chan,
   clpf_rsp_if.source rsp_chan
);
   import clpf_pkg::*;

   item_type item;
   logic     item_valid;
   logic     item_take;
   run_type  run;
   logic     run_free;

   // Register incoming requests
   clpf_intake u_intake (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item       (item),
      .item_valid (item_valid),
      .item_take  (item_take)
   );

   // Expand into a byte run and update frame state
   clpf_build u_build (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_take  (item_take),
      .run_free   (run_free),
      .run        (run)
   );

   // Shift bytes out
   clpf_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .run      (run),
      .run_load (item_take),
      .run_free (run_free),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/clpf_checker.sv =====
// ----------------------------------------------------------------------------
// Framer port checker
// Watches the response port for framing and handshake slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc32_length_prefixed_framer_unit_assert.svh"

module clpf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic [1:0]  rsp_byte_kind,
   input wire logic        rsp_end_of_frame,
   input wire logic        rsp_last_of_run
);
   import clpf_pkg::*;

   // Frame end always closes the run
   `CLPF_ASSERT_NOW(a_eof_last, clock, reset, rsp_valid && rsp_end_of_frame, rsp_last_of_run, "frame end not last of run")

   // Frame end only on a CRC byte
   `CLPF_ASSERT_NOW(a_eof_crc, clock, reset, rsp_valid && rsp_end_of_frame, rsp_byte_kind == KIND_CRC, "frame end on non-CRC byte")

   // A header byte is always followed by more of the same run
   `CLPF_ASSERT_NOW(a_hdr_not_last, clock, reset, rsp_valid && (rsp_byte_kind == KIND_HEADER), !rsp_last_of_run, "run ends on header byte")

   // Hold a stalled response
   `CLPF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte), "stalled response changed")

endmodule

bind crc32_length_prefixed_framer_unit clpf_checker u_clpf_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_out_byte     (rsp_chan.out_byte),
   .rsp_byte_kind    (rsp_chan.byte_kind),
   .rsp_end_of_frame (rsp_chan.end_of_frame),
   .rsp_last_of_run  (rsp_chan.last_of_run)
);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed CRC-32 framer testbench
// Streams payload frames of random and edge-case lengths into the framer,
// predicts the header, payload and CRC byte stream per request, and checks
// every output byte field by field under random stalls on both channels.
// ----------------------------------------------------------------------------

// Predicts the framed byte stream and checks the block's output against it
class framer_scoreboard;
   typedef struct {
      logic [clpf_pkg::BYTE_W-1:0] data;
      clpf_pkg::byte_kind_type     kind;
      logic                        eof;
      logic                        last;
   } framed_byte_type;

   framed_byte_type            pending_q[$];
   logic [clpf_pkg::CRC_W-1:0] crc_acc;
   logic [clpf_pkg::LEN_W-1:0] bytes_left;
   bit                         in_frame;
   int                         errors;

   function new();
      crc_acc    = '0;
      bytes_left = '0;
      in_frame   = 1'b0;
      errors     = 0;
   endfunction

   // Shift one byte into the CRC, MSB first, one bit per step
   function logic [clpf_pkg::CRC_W-1:0] crc_advance(input logic [clpf_pkg::CRC_W-1:0] crc,
                                                    input logic [clpf_pkg::BYTE_W-1:0] b);
      logic feedback;
      for (int i = clpf_pkg::BYTE_W - 1; i >= 0; i--) begin
         feedback = crc[clpf_pkg::CRC_W-1] ^ b[i];
         crc = {crc[clpf_pkg::CRC_W-2:0], 1'b0};
         if (feedback) begin
            crc = crc ^ clpf_pkg::CRC_POLY;
         end
      end
      return crc;
   endfunction

   function framed_byte_type framed(input logic [clpf_pkg::BYTE_W-1:0] data,
                                    input clpf_pkg::byte_kind_type kind, input logic eof);
      framed_byte_type fb;
      fb.data = data;
      fb.kind = kind;
      fb.eof  = eof;
      fb.last = 1'b0;
      return fb;
   endfunction

   // Expand one accepted request into the bytes it must produce
   function void note_request(input logic [clpf_pkg::BYTE_W-1:0] pb,
                              input logic [clpf_pkg::LEN_W-1:0] fl);
      framed_byte_type            run[clpf_pkg::RUN_SLOTS];
      logic [clpf_pkg::LEN_W-1:0] len;
      int                         n;
      n = 0;
      // open a frame: header bytes seed the CRC from zero
      if (!in_frame) begin
         len = (fl == '0) ? 16'd1 : fl;
         crc_acc = crc_advance(crc_advance('0, len[15:8]), len[7:0]);
         run[n++] = framed(len[15:8], clpf_pkg::KIND_HEADER, 1'b0);
         run[n++] = framed(len[7:0], clpf_pkg::KIND_HEADER, 1'b0);
         bytes_left = len;
         in_frame = 1'b1;
      end
      crc_acc = crc_advance(crc_acc, pb);
      run[n++] = framed(pb, clpf_pkg::KIND_PAYLOAD, 1'b0);
      bytes_left = bytes_left - 1'b1;
      // close the frame: append the CRC big-endian
      if (bytes_left == '0) begin
         for (int i = 0; i < clpf_pkg::CRC_BYTES; i++) begin
            run[n++] = framed(crc_acc[31 - 8*i -: 8], clpf_pkg::KIND_CRC,
                              (i == clpf_pkg::CRC_BYTES - 1));
         end
         crc_acc = '0;
         in_frame = 1'b0;
      end
      run[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) begin
         pending_q = {pending_q, run[k]};
      end
   endfunction

   // Compare one output byte with the oldest prediction
   function void check_byte(input logic [clpf_pkg::BYTE_W-1:0] data, input logic [1:0] kind,
                            input logic eof, input logic last);
      framed_byte_type want;
      if (pending_q.size() == 0) begin
         $error("out_byte: unexpected output %0h with nothing pending", data);
         errors++;
         return;
      end
      want = pending_q.pop_front();
      if (data !== want.data) begin
         $error("out_byte: expected %0h, got %0h", want.data, data);
         errors++;
      end
      if (kind !== want.kind) begin
         $error("byte_kind: expected %0d, got %0d", want.kind, kind);
         errors++;
      end
      if (eof !== want.eof) begin
         $error("end_of_frame: expected %0b, got %0b", want.eof, eof);
         errors++;
      end
      if (last !== want.last) begin
         $error("last_of_run: expected %0b, got %0b", want.last, last);
         errors++;
      end
   endfunction
endclass

module testbench;
   import clpf_pkg::*;

   logic             clock = 1'b0;
   logic             reset;
   clpf_req_if       req_chan ();
   clpf_rsp_if       rsp_chan ();
   framer_scoreboard board;
   int               requests_sent;
   bit               send_burst;
   bit               recv_burst;

   crc32_length_prefixed_framer_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int idle_cycles(input bit burst);
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // Offer one request at the falling edge and hold it until accepted
   task automatic send_request(input logic [BYTE_W-1:0] pb, input logic [LEN_W-1:0] fl);
      int gap;
      gap = idle_cycles(send_burst);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        = 1'b1;
      req_chan.payload_byte = pb;
      req_chan.frame_length = fl;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      board.note_request(pb, fl);
      requests_sent++;
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      @(negedge clock);
   endtask

   // Send a frame's bytes; later bytes carry random lengths the block must ignore
   task automatic offer_frame(input logic [LEN_W-1:0] len_field, input int count);
      for (int k = 0; k < count; k++) begin
         send_request(BYTE_W'($urandom_range(0, 255)),
                      (k == 0) ? len_field : LEN_W'($urandom_range(0, 65535)));
      end
   endtask

   // Result side: random stalls, one long hold-off, check on every handshake
   initial begin
      int stall_left;
      bit held_off;
      rsp_chan.ready = 1'b0;
      stall_left = 0;
      held_off = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && requests_sent >= 180) begin
            held_off = 1'b1;
            stall_left = 80;
         end
         if (stall_left > 0) begin
            rsp_chan.ready = 1'b0;
            stall_left--;
         end else begin
            stall_left = idle_cycles(recv_burst);
            rsp_chan.ready = (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready) begin
            board.check_byte(rsp_chan.out_byte, rsp_chan.byte_kind,
                             rsp_chan.end_of_frame, rsp_chan.last_of_run);
         end
         if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
      end
   end

   // Stimulus: directed frames, random frames, then an open maximum-length frame
   initial begin
      int r;
      int len;
      board = new();
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload_byte = '0;
      req_chan.frame_length = '0;
      requests_sent = 0;
      send_burst = 1'b0;
      recv_burst = 1'b0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // zero length is taken as a one-byte frame
      send_request(8'hA5, 16'h0000);
      // one-byte frames at the byte extremes
      send_request(8'hFF, 16'h0001);
      send_request(8'h00, 16'h0001);
      // later bytes of a frame carry lengths that must be ignored
      send_request(8'h00, 16'h0003);
      send_request(8'hFF, 16'hFFFF);
      send_request(8'h5A, 16'h0000);
      send_request(8'h80, 16'h0002);
      send_request(8'h01, 16'h8000);
      offer_frame(16'd5, 5);
      offer_frame(16'd12, 12);

      // random frames, mostly short
      while (requests_sent < 445) begin
         r = $urandom_range(0, 99);
         if (r < 8) len = 0;
         else if (r < 85) len = $urandom_range(1, 8);
         else len = $urandom_range(9, 40);
         offer_frame(LEN_W'(len), (len == 0) ? 1 : len);
      end

      // maximum length header; the frame stays open at the end of the run
      offer_frame(16'hFFFF, 6);
      req_chan.valid = 1'b0;

      // drain, then watch for stray output
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Abort a hung run
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
